### rtl/tsr_pkg.sv
// Shared widths and stream packing constants for the TCP stream reassembler.
// No dependencies; imported by the top level.
package tsr_pkg;

  // Field widths
  localparam int IDX_W  = 32;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;
  localparam int FREE_W = 7;

  // Stream bus widths (tdata padded to whole bytes)
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 48;
  localparam int S_USER_W = 2;
  localparam int M_USER_W = 2;

  // Input tdata field positions
  localparam int S_IDX_LSB  = 0;
  localparam int S_BYTE_LSB = IDX_W;
  localparam int S_FREE_LSB = IDX_W + BYTE_W;

  // Input tuser flag positions
  localparam int S_HAS_BIT = 0;
  localparam int S_EOF_BIT = 1;

endpackage

### rtl/tsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tcp_stream_reassembler.sv
// Byte stream reassembler: window ring of CAPACITY bytes with valid bits.
// Depends on tsr_pkg and tsr_ram.
// An item without tlast is placed in the window on accept and ready stays high.
// An item with tlast starts a drain: with an empty head slot a status-only
// result is loaded; else each byte takes a RAM read at head, then an output
// load when the output slot is free; ready is low until the last is loaded.
// The read/load loop on the single window RAM read port sets the drain pace.
// Reset (rst, sync, active high) clears valid bits, head, indexes, counts and
// flags; window byte storage is not cleared.
module tcp_stream_reassembler #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // byte_index[31:0], data_byte[39:32], out_free[46:40], pad[47]
  input  logic [tsr_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // has_byte[0], seg_eof[1]
  input  logic [tsr_pkg::S_USER_W-1:0]  s_axis_tuser,
  input  logic                          s_axis_tlast,
  // master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_byte[7:0], ack_next[39:8], pending_count[46:40], pad[47]
  output logic [tsr_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // out_valid[0], input_ended[1]
  output logic [tsr_pkg::M_USER_W-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast
);

  import tsr_pkg::*;

  localparam int SW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state;

  // window state
  logic [CAPACITY-1:0] valid;
  logic [SW-1:0]       head;
  logic [IDX_W-1:0]    next_expected;
  logic [IDX_W-1:0]    end_position;
  logic [CNT_W-1:0]    pending;
  logic                eof_known;
  logic                ended;

  // output payload registers
  logic [BYTE_W-1:0] out_byte;
  logic              out_valid;
  logic              out_ended;
  logic [IDX_W-1:0]  out_ack;
  logic [CNT_W-1:0]  out_pending;
  logic              out_last;

  // input fields
  logic [IDX_W-1:0]  in_index;
  logic [BYTE_W-1:0] in_byte;
  logic [FREE_W-1:0] in_free;
  logic              in_has;
  logic              in_eof;
  logic              in_end;

  assign in_index = s_axis_tdata[S_IDX_LSB +: IDX_W];
  assign in_byte  = s_axis_tdata[S_BYTE_LSB +: BYTE_W];
  assign in_free  = s_axis_tdata[S_FREE_LSB +: FREE_W];
  assign in_has   = s_axis_tuser[S_HAS_BIT];
  assign in_eof   = s_axis_tuser[S_EOF_BIT];
  assign in_end   = s_axis_tlast;

  logic accept;
  logic out_slot_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_slot_free = !m_axis_tvalid || m_axis_tready;

  // window placement: offset from next expected, clamped room, ring slot
  logic [FREE_W-1:0] room;
  logic [IDX_W:0]    diff;
  logic              in_range;
  logic [SW:0]       slot_sum;
  logic [SW-1:0]     slot;

  always_comb begin
    room     = (in_free > FREE_W'(CAPACITY)) ? FREE_W'(CAPACITY) : in_free;
    diff     = {1'b0, in_index} - {1'b0, next_expected};
    in_range = !diff[IDX_W] && (diff[IDX_W-1:0] < {{(IDX_W-FREE_W){1'b0}}, room});
    slot_sum = {1'b0, head} + diff[SW:0];
    if (slot_sum >= (SW+1)'(CAPACITY)) begin
      slot = SW'(slot_sum - (SW+1)'(CAPACITY));
    end else begin
      slot = slot_sum[SW-1:0];
    end
  end

  // head advance and end checks
  logic [SW-1:0]    head_inc;
  logic [IDX_W-1:0] next_inc;
  logic             ended_chk;
  logic             ended_emit;
  logic             more_after;

  always_comb begin
    head_inc   = (head == SW'(CAPACITY - 1)) ? '0 : head + 1'b1;
    next_inc   = next_expected + 1'b1;
    ended_chk  = ended || (eof_known && (next_expected == end_position));
    ended_emit = ended || (eof_known && (next_inc == end_position));
    more_after = valid[head_inc];
  end

  // window byte store
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  assign ram_we = accept && in_has && in_range && !valid[slot];
  assign ram_re = (state == ST_DRAIN) && valid[head];

  tsr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(CAPACITY)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata(in_byte),
    .re   (ram_re),
    .raddr(head),
    .rdata(ram_rdata)
  );

  // result register load strobe
  logic out_load;

  assign out_load = out_slot_free &&
                    (((state == ST_DRAIN) && !valid[head]) || (state == ST_EMIT));

  // sequencer: store on accept, drain the head on segment end
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= '0;
      head          <= '0;
      next_expected <= '0;
      end_position  <= '0;
      pending       <= '0;
      eof_known     <= 1'b0;
      ended         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // result valid: set on load, cleared once taken
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_has) begin
              if (in_range) begin
                if (!valid[slot]) begin
                  valid[slot] <= 1'b1;
                  pending     <= pending + 1'b1;
                end
                if (in_eof && in_end) begin
                  eof_known    <= 1'b1;
                  end_position <= in_index + 1'b1;
                end
              end
            end else if (in_eof && (pending == '0)) begin
              ended <= 1'b1;
            end
            if (in_end) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (valid[head]) begin
            // head read issued this cycle
            ended <= ended_chk;
            state <= ST_EMIT;
          end else if (out_slot_free) begin
            // nothing to drain: status only
            ended         <= ended_chk;
            out_byte      <= '0;
            out_valid     <= 1'b0;
            out_ended     <= ended_chk;
            out_ack       <= next_expected;
            out_pending   <= pending;
            out_last      <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_slot_free) begin
            valid[head]   <= 1'b0;
            head          <= head_inc;
            next_expected <= next_inc;
            pending       <= (pending != '0) ? pending - 1'b1 : pending;
            ended         <= ended_emit;
            out_byte      <= ram_rdata;
            out_valid     <= 1'b1;
            out_ended     <= ended_emit;
            out_ack       <= next_inc;
            out_pending   <= (pending != '0) ? pending - 1'b1 : pending;
            out_last      <= !more_after;
            state         <= more_after ? ST_DRAIN : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output packing
  assign m_axis_tdata = {1'b0, out_pending, out_ack, out_byte};
  assign m_axis_tuser = {out_ended, out_valid};
  assign m_axis_tlast = out_last;

  // checks
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(CAPACITY))
    else $error("pending count exceeds window capacity");

  a_ended_sticky: assert property (@(posedge clk) disable iff (rst)
    ended |=> ended)
    else $error("end of input dropped");

  a_emit_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> valid[head])
    else $error("emitting from an empty head slot");

  a_emit_advance: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && out_slot_free) |=>
      (next_expected == $past(next_expected) + 32'd1))
    else $error("ack index did not advance on a delivered byte");

  a_status_form: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata[7:0] == 8'd0)))
    else $error("status item malformed");

endmodule
